FILE: design/pdisp_pkg.sv
// Shared types and constants for the periodic task dispatcher.
// No dependencies; every other design file imports this package.
package pdisp_pkg;

    localparam int MAX_TASKS_DEF = 8;
    localparam int HANDLE_W      = 4;
    localparam int PERIOD_W      = 16;
    localparam int STAT_W        = 32;
    localparam int IN_DATA_W     = 56;
    localparam int OUT_DATA_W    = 104;
    localparam int ACTION_W      = 3;
    localparam int KIND_W        = 3;
    localparam int STATE_W       = 3;

    localparam logic [STAT_W-1:0] STAT_MIN_INIT = 32'hFFFF_FFFF;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK       = 3'd0,
        ACT_CREATE     = 3'd1,
        ACT_STEP       = 3'd2,
        ACT_FORCE      = 3'd3,
        ACT_INIT_DONE  = 3'd4,
        ACT_RUN_DONE   = 3'd5,
        ACT_FORCE_DONE = 3'd6,
        ACT_QUERY      = 3'd7
    } action_t;

    typedef enum logic [KIND_W-1:0] {
        RES_NONE      = 3'd0,
        RES_CALL_INIT = 3'd1,
        RES_CALL_RUN  = 3'd2,
        RES_CREATED   = 3'd3,
        RES_FULL      = 3'd4,
        RES_STATS     = 3'd5
    } kind_t;

    typedef enum logic [STATE_W-1:0] {
        ST_WAITING = 3'd0,
        ST_INIT    = 3'd1,
        ST_READY   = 3'd2,
        ST_RUNNING = 3'd3,
        ST_END_RUN = 3'd4
    } status_t;

    typedef struct packed {
        logic [HANDLE_W-1:0]        task_handle;
        logic                       wants_init;
        logic                       wants_run;
        logic signed [PERIOD_W-1:0] run_period;
        logic                       init_ok;
        logic [STAT_W-1:0]          elapsed_ticks;
    } req_t;

    typedef struct packed {
        kind_t               result_kind;
        logic [HANDLE_W-1:0] result_handle;
        logic [STATE_W-1:0]  task_state;
        logic [STAT_W-1:0]   use_total_out;
        logic [STAT_W-1:0]   use_min_out;
        logic [STAT_W-1:0]   use_max_out;
    } res_t;

    // Slot selection flags handed from the selector to the table.
    typedef struct packed {
        logic hit;   // handle names a used slot
        logic full;  // no free slot for a create
    } sel_flags_t;

endpackage

FILE: design/pdisp_slot_pick.sv
// Slot selector: picks the table entry a request works on.
// Depends on pdisp_pkg.
module pdisp_slot_pick
    import pdisp_pkg::*;
#(
    parameter int  MAX_TASKS = MAX_TASKS_DEF,
    localparam int SLOT_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
)
(
    input  action_t               action,
    input  logic [HANDLE_W-1:0]   task_handle,
    input  logic [MAX_TASKS-1:0]  used,
    input  logic [SLOT_W-1:0]     scan,
    output logic [SLOT_W-1:0]     idx,
    output sel_flags_t            flags
);

    logic [HANDLE_W-1:0] hnd_slot;
    logic [SLOT_W-1:0]   free_idx;
    logic                free_found;
    logic                in_range;

    assign hnd_slot = task_handle - HANDLE_W'(1);
    assign in_range = (task_handle != '0) &&
                      ({1'b0, task_handle} <= (HANDLE_W + 1)'(MAX_TASKS));

    // Lowest free slot wins.
    always_comb
    begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = MAX_TASKS - 1; i >= 0; i--)
        begin
            if (!used[i])
            begin
                free_idx   = SLOT_W'(i);
                free_found = 1'b1;
            end
        end
    end

    always_comb
    begin
        case (action)
            ACT_CREATE: idx = free_idx;
            ACT_STEP:   idx = scan;
            default:    idx = hnd_slot[SLOT_W-1:0];
        endcase
    end

    assign flags.hit  = in_range && used[hnd_slot[SLOT_W-1:0]];
    assign flags.full = !free_found;

endmodule

FILE: design/pdisp_table.sv
// Task table: per-slot flags, status, period, countdown and run statistics,
// with the update logic for one request. Depends on pdisp_pkg.
module pdisp_table
    import pdisp_pkg::*;
#(
    parameter int  MAX_TASKS = MAX_TASKS_DEF,
    localparam int SLOT_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  upd_en,
    input  action_t               action,
    input  req_t                  req,
    input  logic [SLOT_W-1:0]     idx,
    input  sel_flags_t            flags,
    output logic [MAX_TASKS-1:0]  used,
    output logic [SLOT_W-1:0]     scan,
    output res_t                  res
);

    logic [MAX_TASKS-1:0] used_reg,      used_next;
    logic [MAX_TASKS-1:0] init_flag_reg, init_flag_next;
    logic [MAX_TASKS-1:0] run_flag_reg,  run_flag_next;
    status_t              status_reg    [MAX_TASKS];
    status_t              status_next   [MAX_TASKS];
    logic [PERIOD_W-1:0]  period_reg    [MAX_TASKS];
    logic [PERIOD_W-1:0]  period_next   [MAX_TASKS];
    logic [PERIOD_W-1:0]  cd_reg        [MAX_TASKS];
    logic [PERIOD_W-1:0]  cd_next       [MAX_TASKS];
    logic [STAT_W-1:0]    total_reg     [MAX_TASKS];
    logic [STAT_W-1:0]    total_next    [MAX_TASKS];
    logic [STAT_W-1:0]    min_reg       [MAX_TASKS];
    logic [STAT_W-1:0]    min_next      [MAX_TASKS];
    logic [STAT_W-1:0]    max_reg       [MAX_TASKS];
    logic [STAT_W-1:0]    max_next      [MAX_TASKS];
    logic [SLOT_W-1:0]    scan_reg,     scan_next;

    logic [HANDLE_W-1:0]  slot_hnd;
    status_t              cur_st;
    status_t              step_st;
    logic [PERIOD_W-1:0]  step_cd;

    assign used     = used_reg;
    assign scan     = scan_reg;
    assign slot_hnd = HANDLE_W'(idx) + HANDLE_W'(1);
    assign cur_st   = status_reg[idx];

    // A finished run reloads its countdown on the visit that sees it at zero.
    always_comb
    begin
        step_st = cur_st;
        step_cd = cd_reg[idx];
        if (cur_st == ST_END_RUN && cd_reg[idx] == '0)
        begin
            step_st = ST_READY;
            step_cd = period_reg[idx];
        end
    end

    always_comb
    begin
        used_next      = used_reg;
        init_flag_next = init_flag_reg;
        run_flag_next  = run_flag_reg;
        status_next    = status_reg;
        period_next    = period_reg;
        cd_next        = cd_reg;
        total_next     = total_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        scan_next      = scan_reg;
        res            = '0;
        res.result_kind = RES_NONE;

        case (action)
            ACT_TICK:
            begin
                for (int i = 0; i < MAX_TASKS; i++)
                begin
                    if (status_reg[i] == ST_READY && cd_reg[i] != '0 &&
                        !cd_reg[i][PERIOD_W-1])
                    begin
                        cd_next[i] = cd_reg[i] - PERIOD_W'(1);
                    end
                end
            end
            ACT_CREATE:
            begin
                if (flags.full)
                begin
                    res.result_kind = RES_FULL;
                end
                else
                begin
                    used_next[idx]      = 1'b1;
                    init_flag_next[idx] = req.wants_init;
                    run_flag_next[idx]  = req.wants_run;
                    status_next[idx]    = req.wants_init ? ST_INIT :
                                          (req.wants_run ? ST_READY : ST_WAITING);
                    period_next[idx]    = req.run_period;
                    cd_next[idx]        = req.run_period;
                    total_next[idx]     = '0;
                    min_next[idx]       = STAT_MIN_INIT;
                    max_next[idx]       = '0;
                    res.result_kind     = RES_CREATED;
                    res.result_handle   = slot_hnd;
                end
            end
            ACT_STEP:
            begin
                if (used_reg[idx])
                begin
                    if (init_flag_reg[idx] && cur_st == ST_INIT)
                    begin
                        res.result_kind   = RES_CALL_INIT;
                        res.result_handle = slot_hnd;
                    end
                    else if (run_flag_reg[idx])
                    begin
                        status_next[idx] = step_st;
                        cd_next[idx]     = step_cd;
                        if (step_st == ST_READY && step_cd == '0)
                        begin
                            status_next[idx]  = ST_RUNNING;
                            res.result_kind   = RES_CALL_RUN;
                            res.result_handle = slot_hnd;
                        end
                    end
                end
                scan_next = (scan_reg == SLOT_W'(MAX_TASKS - 1)) ? '0 :
                            scan_reg + SLOT_W'(1);
            end
            ACT_FORCE:
            begin
                if (flags.hit && run_flag_reg[idx])
                begin
                    status_next[idx]  = ST_RUNNING;
                    res.result_kind   = RES_CALL_RUN;
                    res.result_handle = slot_hnd;
                end
            end
            ACT_INIT_DONE:
            begin
                if (flags.hit && init_flag_reg[idx] && cur_st == ST_INIT)
                begin
                    status_next[idx] = req.init_ok ? ST_READY : ST_WAITING;
                end
            end
            ACT_RUN_DONE:
            begin
                if (flags.hit && cur_st == ST_RUNNING)
                begin
                    status_next[idx] = ST_END_RUN;
                    total_next[idx]  = total_reg[idx] + req.elapsed_ticks;
                    if (req.elapsed_ticks < min_reg[idx])
                    begin
                        min_next[idx] = req.elapsed_ticks;
                    end
                    if (req.elapsed_ticks > max_reg[idx])
                    begin
                        max_next[idx] = req.elapsed_ticks;
                    end
                end
            end
            ACT_FORCE_DONE:
            begin
                if (flags.hit && cur_st == ST_RUNNING)
                begin
                    status_next[idx] = ST_END_RUN;
                end
            end
            default:
            begin
                if (flags.hit)
                begin
                    res.result_kind   = RES_STATS;
                    res.result_handle = slot_hnd;
                    res.task_state    = cur_st;
                    res.use_total_out = total_reg[idx];
                    res.use_min_out   = min_reg[idx];
                    res.use_max_out   = max_reg[idx];
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
            scan_reg <= '0;
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                status_reg[i] <= ST_WAITING;
            end
        end
        else if (upd_en)
        begin
            used_reg    <= used_next;
            scan_reg    <= scan_next;
            status_reg  <= status_next;
        end
    end

    // Entry payload is only read once a create has written it.
    always_ff @(posedge clk)
    begin
        if (upd_en)
        begin
            init_flag_reg <= init_flag_next;
            run_flag_reg  <= run_flag_next;
            period_reg    <= period_next;
            cd_reg        <= cd_next;
            total_reg     <= total_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
        end
    end

endmodule

FILE: design/periodic_task_dispatcher_top.sv
// Periodic task dispatcher top level: stream ports, request and result
// registers. Depends on pdisp_pkg, pdisp_slot_pick and pdisp_table.
//
// The dispatcher holds a table of MAX_TASKS task slots and answers every
// request with exactly one result: tick, create, step (round-robin visit),
// force, init/run/force completions and statistics query. Each request
// is captured in the request register; the selected slot is then read,
// updated and its result written to the result register once that is free
// or being emptied. Throughput is one request per clock while results are
// taken on m_axis_tready. The result is presented on the master side from
// the result register. The table update (slot select, a 32-bit add and two
// compares) is combinational between the two registers. The result register
// and the request register decouple the two sides, so a new request can be
// taken into a free request register while a finished result waits for
// m_axis_tready.
// Slot handles are slot+1; a handle of 0, beyond MAX_TASKS or of an unused
// slot gives result kind "nothing" with all fields zero.
module periodic_task_dispatcher_top
    import pdisp_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // tdata: task_handle[3:0], wants_init[4], wants_run[5], run_period[21:6],
    //        init_ok[22], elapsed_ticks[54:23], zero pad[55]
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,
    // tuser: action[2:0]
    input  logic [ACTION_W-1:0]    s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // tdata: result_handle[3:0], task_state[6:4], use_total_out[38:7],
    //        use_min_out[70:39], use_max_out[102:71], zero pad[103]
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    // tuser: result_kind[2:0]
    output logic [KIND_W-1:0]      m_axis_tuser
);

    localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

    logic                 in_valid_reg, in_valid_next;
    action_t              in_action_reg;
    req_t                 in_req_reg;
    logic                 out_valid_reg, out_valid_next;
    res_t                 out_res_reg;

    logic                 advance;
    logic                 in_take;
    logic [MAX_TASKS-1:0] used;
    logic [SLOT_W-1:0]    scan;
    logic [SLOT_W-1:0]    idx;
    sel_flags_t           flags;
    res_t                 res;

    // Move the held request into the result register when that is free
    // or being emptied this cycle.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 :
                         (m_axis_tready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the request fields on a take, and the table result on an advance.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_action_reg            <= action_t'(s_axis_tuser);
            in_req_reg.task_handle   <= s_axis_tdata[3:0];
            in_req_reg.wants_init    <= s_axis_tdata[4];
            in_req_reg.wants_run     <= s_axis_tdata[5];
            in_req_reg.run_period    <= s_axis_tdata[21:6];
            in_req_reg.init_ok       <= s_axis_tdata[22];
            in_req_reg.elapsed_ticks <= s_axis_tdata[54:23];
        end
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    pdisp_slot_pick #(
        .MAX_TASKS (MAX_TASKS)
    ) u_pick (
        .action      (in_action_reg),
        .task_handle (in_req_reg.task_handle),
        .used        (used),
        .scan        (scan),
        .idx         (idx),
        .flags       (flags)
    );

    pdisp_table #(
        .MAX_TASKS (MAX_TASKS)
    ) u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .upd_en (advance),
        .action (in_action_reg),
        .req    (in_req_reg),
        .idx    (idx),
        .flags  (flags),
        .used   (used),
        .scan   (scan),
        .res    (res)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.result_kind;
    assign m_axis_tdata  = {1'b0,
                            out_res_reg.use_max_out,
                            out_res_reg.use_min_out,
                            out_res_reg.use_total_out,
                            out_res_reg.task_state,
                            out_res_reg.result_handle};

endmodule

FILE: design/pdisp_checker.sv
// Port-level checker for the periodic task dispatcher, bound to the top.
// Depends on pdisp_pkg and periodic_task_dispatcher_top.
module pdisp_checker
    import pdisp_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [IN_DATA_W-1:0]  s_axis_tdata,
    input logic [ACTION_W-1:0]   s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [KIND_W-1:0]     m_axis_tuser
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Only defined result kinds come out.
    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser <= RES_STATS)
        else $error("undefined result kind");

    // Only statistics results carry status and usage fields.
    a_stats_only: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser != RES_STATS |->
            m_axis_tdata[OUT_DATA_W-1:HANDLE_W] == '0)
        else $error("non-statistics result carries statistics");

    // Nothing and table-full results name no handle.
    a_no_handle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == RES_NONE || m_axis_tuser == RES_FULL) |->
            m_axis_tdata[HANDLE_W-1:0] == '0)
        else $error("handle on empty result");

    // An idle dispatcher with a free result side takes a request.
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid && !$past(s_axis_tvalid && s_axis_tready) |-> s_axis_tready)
        else $error("request refused while idle");

endmodule

bind periodic_task_dispatcher_top pdisp_checker u_pdisp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
